[rtl/core/bth_pkg.sv]
// Shared types and constants for the boundary-tag heap allocator.
// No dependencies; bth_ifs, bth_engine and the top level refer to this package.
package bth_pkg;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned REQ_W = 32;
	localparam int unsigned NEED_W = REQ_W + 2;
	localparam int unsigned BYTES_W = 17;
	localparam int unsigned COUNT_W = 11;

	localparam int unsigned GRAN_BYTES = 16;
	localparam int unsigned GRAN_SHIFT = 4;
	localparam int unsigned TAGS_BYTES = 32;
	localparam int unsigned MIN_BLOCK_BYTES = 48;
	localparam int unsigned MIN_BLOCK_GRANS = 3;

	// tag flag field: {valid, free}
	localparam logic [1:0] FL_FREE_BLK = 2'b11;
	localparam logic [1:0] FL_USED_BLK = 2'b10;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_ZERO = 3'd1,
		ST_ALIGN = 3'd2,
		ST_CORRUPT = 3'd3,
		ST_NOMEM = 3'd4,
		ST_BADPTR = 3'd5
	} status_t;

	typedef struct packed {
		logic mode;
		logic [REQ_W-1:0] request_bytes;
		logic [REQ_W-1:0] alignment;
		logic [ADDR_W-1:0] payload_address;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic [ADDR_W-1:0] granted_address;
		logic [BYTES_W-1:0] bytes_in_use;
		logic [COUNT_W-1:0] used_block_count;
		logic [COUNT_W-1:0] free_block_count;
	} result_t;

endpackage

[rtl/core/bth_ifs.sv]
// Handshake interfaces for the allocator: request channel and result channel.
// Depends on bth_pkg for field widths and the status type.
interface bth_req_if;
	logic valid;
	logic ready;
	logic mode;
	logic [bth_pkg::REQ_W-1:0] request_bytes;
	logic [bth_pkg::REQ_W-1:0] alignment;
	logic [bth_pkg::ADDR_W-1:0] payload_address;

	modport source(output valid, mode, request_bytes, alignment, payload_address, input ready);
	modport sink(input valid, mode, request_bytes, alignment, payload_address, output ready);
endinterface

interface bth_rsp_if;
	logic valid;
	logic ready;
	bth_pkg::status_t status;
	logic [bth_pkg::ADDR_W-1:0] granted_address;
	logic [bth_pkg::BYTES_W-1:0] bytes_in_use;
	logic [bth_pkg::COUNT_W-1:0] used_block_count;
	logic [bth_pkg::COUNT_W-1:0] free_block_count;

	modport source(output valid, status, granted_address, bytes_in_use, used_block_count,
		free_block_count, input ready);
	modport sink(input valid, status, granted_address, bytes_in_use, used_block_count,
		free_block_count, output ready);
endinterface

[rtl/core/bth_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bth_ram #(
	parameter int unsigned WIDTH = 15,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/bth_engine.sv]
// Sequencer of the allocator: clearing pass, partition check, first-fit search,
// release with merging, all as read-modify-write on the tag RAM. Uses bth_pkg, bth_ram.
module bth_engine #(
	parameter int unsigned ARENA_GRANULES = 4096,
	parameter int unsigned ALIGN_MIN = 16,
	parameter int unsigned ALIGN_MAX = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  bth_pkg::cmd_t               cmd,
	input  logic [bth_pkg::ADDR_W-1:0]  base,
	output logic                        idle,
	output logic                        res_valid,
	input  logic                        res_take,
	output bth_pkg::result_t            res
);

	localparam int unsigned IDX_W = $clog2(ARENA_GRANULES);
	localparam int unsigned SZ_W = $clog2(ARENA_GRANULES + 1);
	localparam int unsigned TAG_W = SZ_W + 2;
	localparam int unsigned UB_W = $clog2(ARENA_GRANULES * bth_pkg::GRAN_BYTES + 1);
	localparam int unsigned AL_W = $clog2(ALIGN_MAX) + 1;
	localparam int unsigned GP_W = AL_W + 2;
	localparam int unsigned CW = (SZ_W + 5 > bth_pkg::NEED_W + 2) ? SZ_W + 5
		: bth_pkg::NEED_W + 2;
	localparam logic [SZ_W-1:0] AG_S = SZ_W'(ARENA_GRANULES);
	localparam logic [SZ_W-1:0] MINB_S = SZ_W'(bth_pkg::MIN_BLOCK_GRANS);
	localparam logic [SZ_W-1:0] ONE_S = SZ_W'(1);
	localparam logic [bth_pkg::ADDR_W-1:0] ARENA_SPAN =
		bth_pkg::ADDR_W'(ARENA_GRANULES) * bth_pkg::ADDR_W'(bth_pkg::GRAN_BYTES);
	localparam logic [bth_pkg::ADDR_W-1:0] GRAN_A = bth_pkg::ADDR_W'(bth_pkg::GRAN_BYTES);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CHECK,
		S_V_HEAD_RD, S_V_HEAD, S_V_FOOT,
		S_A_RD, S_A_HEAD, S_A_FIT,
		S_W_GAP_H, S_W_GAP_F, S_W_USE_H, S_W_USE_F, S_W_TAIL_H, S_W_TAIL_F,
		S_R_RD, S_R_CHK, S_R_NEXT, S_W_REL_H, S_W_REL_F,
		S_DONE
	} state_t;

	state_t state_q;
	bth_pkg::cmd_t cmd_q;
	bth_pkg::status_t status_q;
	logic [bth_pkg::ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0] clr_q;
	logic [SZ_W-1:0] cur_q, n_q, target_q, prev_q, prev_size_q;
	logic [SZ_W-1:0] gap_g_q, use_g_q, tail_g_q, chosen_q, released_q;
	logic [SZ_W-1:0] rel_start_q, rel_size_q;
	logic [1:0] fl_q;
	logic prev_free_q, has_prev_q, prev_is_free_q, next_in_q;
	logic [UB_W-1:0] acc_used_q, used_bytes_q;
	logic [SZ_W-1:0] acc_nused_q, acc_nfree_q, used_blocks_q, free_blocks_q;
	logic [bth_pkg::NEED_W-1:0] needed_q;
	logic [GP_W-1:0] gap_q;

	// tag RAM
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [TAG_W-1:0] ram_wdata, rd;
	logic [SZ_W-1:0] raddr_full;
	logic [SZ_W-1:0] rd_size;
	logic [1:0] rd_fl;

	bth_ram #(.WIDTH(TAG_W), .DEPTH(ARENA_GRANULES)) u_tags (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(rd)
	);

	assign rd_size = rd[SZ_W-1:0];
	assign rd_fl = rd[TAG_W-1:SZ_W];

	function automatic logic [TAG_W-1:0] mk_tag(input logic fr, input logic [SZ_W-1:0] n);
		return {1'b1, fr, n};
	endfunction

	// request checks
	logic [bth_pkg::ADDR_W-1:0] off;
	logic bad_ptr, bad_align;
	logic [bth_pkg::NEED_W-1:0] needed;
	logic [SZ_W-1:0] off_g;

	always_comb begin
		off = cmd_q.payload_address - base;
		bad_ptr = (off < GRAN_A) || (off >= ARENA_SPAN) || (cmd_q.payload_address[3:0] != 4'd0);
		off_g = off[SZ_W+3:4];
		bad_align = (cmd_q.alignment < 32'(ALIGN_MIN)) || (cmd_q.alignment > 32'(ALIGN_MAX))
			|| ((cmd_q.alignment & (cmd_q.alignment - 32'd1)) != 32'd0);
		needed = ((bth_pkg::NEED_W'(cmd_q.request_bytes) + bth_pkg::NEED_W'(15))
			& ~bth_pkg::NEED_W'(15)) + bth_pkg::NEED_W'(bth_pkg::TAGS_BYTES);
	end

	// alignment gap of the payload in a candidate block
	logic [CW-1:0] cur_bytes;
	logic [AL_W-1:0] al, al_m, pay_lo, g0;
	logic [GP_W-1:0] g1, g2;
	localparam logic [GP_W-1:0] MINB_GP = GP_W'(bth_pkg::MIN_BLOCK_BYTES);

	always_comb begin
		cur_bytes = CW'(cur_q) << bth_pkg::GRAN_SHIFT;
		al = cmd_q.alignment[AL_W-1:0];
		al_m = al - AL_W'(1);
		pay_lo = base[AL_W-1:0] + cur_bytes[AL_W-1:0] + AL_W'(bth_pkg::GRAN_BYTES);
		g0 = (al - (pay_lo & al_m)) & al_m;
		g1 = (g0 != '0 && GP_W'(g0) < MINB_GP) ? GP_W'(g0) + GP_W'(al) : GP_W'(g0);
		g2 = (g1 != '0 && g1 < MINB_GP) ? g1 + GP_W'(al) : g1;
	end

	// fit test and split of a candidate block
	logic [CW-1:0] blk_b, gap_b, need_b, tail_b, use_b;
	logic fits;

	always_comb begin
		blk_b = CW'(n_q) << bth_pkg::GRAN_SHIFT;
		gap_b = CW'(gap_q);
		need_b = CW'(needed_q);
		fits = (gap_b <= blk_b) && (need_b <= blk_b - gap_b);
		tail_b = blk_b - gap_b - need_b;
		use_b = need_b;
		if (tail_b < CW'(bth_pkg::MIN_BLOCK_BYTES)) begin
			use_b = need_b + tail_b;
			tail_b = '0;
		end
	end

	// release merge
	logic nf, pf;
	logic [SZ_W-1:0] merged;

	always_comb begin
		nf = next_in_q && (rd_fl == bth_pkg::FL_FREE_BLK);
		pf = has_prev_q && prev_is_free_q;
		merged = released_q + (nf ? rd_size : '0) + (pf ? prev_size_q : '0);
	end

	// RAM access per state
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		raddr_full = cur_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == '0 || clr_q == IDX_W'(ARENA_GRANULES - 1)) begin
					ram_wdata = mk_tag(1'b1, AG_S);
				end
			end
			S_V_HEAD: raddr_full = cur_q + rd_size - ONE_S;
			S_R_CHK: raddr_full = cur_q + rd_size;
			S_W_GAP_H: begin
				ram_we = 1'b1;
				ram_waddr = cur_q[IDX_W-1:0];
				ram_wdata = mk_tag(1'b1, gap_g_q);
			end
			S_W_GAP_F: begin
				ram_we = 1'b1;
				ram_waddr = IDX_W'(cur_q + gap_g_q - ONE_S);
				ram_wdata = mk_tag(1'b1, gap_g_q);
			end
			S_W_USE_H: begin
				ram_we = 1'b1;
				ram_waddr = chosen_q[IDX_W-1:0];
				ram_wdata = mk_tag(1'b0, use_g_q);
			end
			S_W_USE_F: begin
				ram_we = 1'b1;
				ram_waddr = IDX_W'(chosen_q + use_g_q - ONE_S);
				ram_wdata = mk_tag(1'b0, use_g_q);
			end
			S_W_TAIL_H: begin
				ram_we = 1'b1;
				ram_waddr = IDX_W'(chosen_q + use_g_q);
				ram_wdata = mk_tag(1'b1, tail_g_q);
			end
			S_W_TAIL_F: begin
				// no tail: nothing to write, the used footer stays
				ram_we = (tail_g_q != '0);
				ram_waddr = IDX_W'(chosen_q + use_g_q + tail_g_q - ONE_S);
				ram_wdata = mk_tag(1'b1, tail_g_q);
			end
			S_W_REL_H: begin
				ram_we = 1'b1;
				ram_waddr = rel_start_q[IDX_W-1:0];
				ram_wdata = mk_tag(1'b1, rel_size_q);
			end
			S_W_REL_F: begin
				ram_we = 1'b1;
				ram_waddr = IDX_W'(rel_start_q + rel_size_q - ONE_S);
				ram_wdata = mk_tag(1'b1, rel_size_q);
			end
			default: raddr_full = cur_q;
		endcase
		ram_raddr = raddr_full[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			used_bytes_q <= '0;
			used_blocks_q <= '0;
			free_blocks_q <= ONE_S;
			status_q <= bth_pkg::ST_OK;
			addr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == IDX_W'(ARENA_GRANULES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						addr_q <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cur_q <= '0;
					acc_used_q <= '0;
					acc_nused_q <= '0;
					acc_nfree_q <= '0;
					prev_free_q <= 1'b0;
					needed_q <= needed;
					target_q <= off_g - ONE_S;
					state_q <= S_V_HEAD_RD;
					if (cmd_q.mode == bth_pkg::MODE_ALLOC) begin
						if (cmd_q.request_bytes == '0) begin
							status_q <= bth_pkg::ST_ZERO;
							state_q <= S_DONE;
						end else if (bad_align) begin
							status_q <= bth_pkg::ST_ALIGN;
							state_q <= S_DONE;
						end
					end else if (bad_ptr) begin
						status_q <= bth_pkg::ST_BADPTR;
						state_q <= S_DONE;
					end
				end
				S_V_HEAD_RD: begin
					if (cur_q == AG_S) begin
						if (acc_used_q != used_bytes_q || acc_nused_q != used_blocks_q
								|| acc_nfree_q != free_blocks_q) begin
							status_q <= bth_pkg::ST_CORRUPT;
							state_q <= S_DONE;
						end else if (cmd_q.mode == bth_pkg::MODE_RELEASE) begin
							cur_q <= '0;
							has_prev_q <= 1'b0;
							state_q <= S_R_RD;
						end else if (needed_q > bth_pkg::NEED_W'(ARENA_SPAN)) begin
							status_q <= bth_pkg::ST_NOMEM;
							state_q <= S_DONE;
						end else begin
							cur_q <= '0;
							state_q <= S_A_RD;
						end
					end else if (AG_S - cur_q < MINB_S) begin
						status_q <= bth_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_V_HEAD;
					end
				end
				S_V_HEAD: begin
					if (!rd_fl[1] || rd_size < MINB_S || rd_size > AG_S - cur_q) begin
						status_q <= bth_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else begin
						n_q <= rd_size;
						fl_q <= rd_fl;
						state_q <= S_V_FOOT;
					end
				end
				S_V_FOOT: begin
					if (rd_size != n_q || rd_fl != fl_q || (fl_q[0] && prev_free_q)) begin
						status_q <= bth_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else begin
						if (fl_q[0]) begin
							acc_nfree_q <= acc_nfree_q + ONE_S;
						end else begin
							acc_nused_q <= acc_nused_q + ONE_S;
							acc_used_q <= acc_used_q + (UB_W'(n_q) << bth_pkg::GRAN_SHIFT);
						end
						prev_free_q <= fl_q[0];
						cur_q <= cur_q + n_q;
						state_q <= S_V_HEAD_RD;
					end
				end
				S_A_RD: begin
					if (cur_q >= AG_S) begin
						status_q <= bth_pkg::ST_NOMEM;
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_HEAD;
					end
				end
				S_A_HEAD: begin
					if (rd_size == '0) begin
						status_q <= bth_pkg::ST_NOMEM;
						state_q <= S_DONE;
					end else if (rd_fl != bth_pkg::FL_FREE_BLK) begin
						cur_q <= cur_q + rd_size;
						state_q <= S_A_RD;
					end else begin
						n_q <= rd_size;
						gap_q <= g2;
						state_q <= S_A_FIT;
					end
				end
				S_A_FIT: begin
					if (!fits) begin
						cur_q <= cur_q + n_q;
						state_q <= S_A_RD;
					end else begin
						gap_g_q <= SZ_W'(gap_b >> bth_pkg::GRAN_SHIFT);
						use_g_q <= SZ_W'(use_b >> bth_pkg::GRAN_SHIFT);
						tail_g_q <= SZ_W'(tail_b >> bth_pkg::GRAN_SHIFT);
						chosen_q <= cur_q + SZ_W'(gap_b >> bth_pkg::GRAN_SHIFT);
						state_q <= (gap_b != '0) ? S_W_GAP_H : S_W_USE_H;
					end
				end
				S_W_GAP_H: state_q <= S_W_GAP_F;
				S_W_GAP_F: state_q <= S_W_USE_H;
				S_W_USE_H: state_q <= S_W_USE_F;
				S_W_USE_F: begin
					if (tail_g_q != '0) begin
						state_q <= S_W_TAIL_H;
					end else begin
						state_q <= S_W_TAIL_F;
					end
				end
				S_W_TAIL_H: state_q <= S_W_TAIL_F;
				S_W_TAIL_F: begin
					// also the bookkeeping step when there is no tail (write suppressed)
					free_blocks_q <= free_blocks_q - ONE_S + SZ_W'(gap_g_q != '0)
						+ SZ_W'(tail_g_q != '0);
					used_bytes_q <= used_bytes_q + (UB_W'(use_g_q) << bth_pkg::GRAN_SHIFT);
					used_blocks_q <= used_blocks_q + ONE_S;
					addr_q <= base + (bth_pkg::ADDR_W'(chosen_q) << bth_pkg::GRAN_SHIFT) + GRAN_A;
					status_q <= bth_pkg::ST_OK;
					state_q <= S_DONE;
				end
				S_R_RD: state_q <= S_R_CHK;
				S_R_CHK: begin
					if (cur_q < target_q) begin
						if (rd_size == '0) begin
							status_q <= bth_pkg::ST_CORRUPT;
							state_q <= S_DONE;
						end else begin
							prev_q <= cur_q;
							prev_size_q <= rd_size;
							prev_is_free_q <= (rd_fl == bth_pkg::FL_FREE_BLK);
							has_prev_q <= 1'b1;
							cur_q <= cur_q + rd_size;
							state_q <= S_R_RD;
						end
					end else if (cur_q != target_q) begin
						status_q <= bth_pkg::ST_BADPTR;
						state_q <= S_DONE;
					end else if (rd_fl != bth_pkg::FL_USED_BLK) begin
						status_q <= bth_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else begin
						released_q <= rd_size;
						next_in_q <= (cur_q + rd_size) < AG_S;
						state_q <= S_R_NEXT;
					end
				end
				S_R_NEXT: begin
					rel_size_q <= merged;
					rel_start_q <= pf ? prev_q : cur_q;
					free_blocks_q <= free_blocks_q + ONE_S - SZ_W'(nf) - SZ_W'(pf);
					used_blocks_q <= used_blocks_q - ONE_S;
					used_bytes_q <= used_bytes_q - (UB_W'(released_q) << bth_pkg::GRAN_SHIFT);
					state_q <= S_W_REL_H;
				end
				S_W_REL_H: state_q <= S_W_REL_F;
				S_W_REL_F: begin
					status_q <= bth_pkg::ST_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status = status_q;
		res.granted_address = addr_q;
		res.bytes_in_use = bth_pkg::BYTES_W'(used_bytes_q);
		res.used_block_count = bth_pkg::COUNT_W'(used_blocks_q);
		res.free_block_count = bth_pkg::COUNT_W'(free_blocks_q);
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> idle) else $error("start while busy");
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != bth_pkg::ST_OK |-> res.granted_address == '0)
		else $error("address on failed operation");
	a_some_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |-> (used_blocks_q != '0 || free_blocks_q != '0))
		else $error("arena holds no block");
	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_bytes_q <= UB_W'(ARENA_GRANULES * bth_pkg::GRAN_BYTES))
		else $error("used bytes beyond arena");

endmodule

[rtl/core/boundary_tag_heap_allocator.sv]
// Top level of the boundary-tag first-fit heap allocator with coalescing.
// Depends on bth_pkg, bth_ifs (bth_req_if, bth_rsp_if) and bth_engine.
//
// channel    dir  words                                         handshake
// req        in   mode, request_bytes, alignment, payload_addr  valid/ready
// rsp        out  status, granted_address, usage counters       valid/ready
// cfg        in   arena_base (64 bits)                          cfg_we, no stall
//
// Sequence: every word that passes the request checks first walks the whole
//   partition, checking head and footer of each block, then a second walk of
//   the blocks visited (allocate also tests each free block it tries for a fit),
//   plus up to 6 tag writes; the single read port of the tag RAM sets the pace.
// Reset: a clearing pass writes every tag RAM entry and leaves one free block;
//   req.ready stays low during it.
// Stalls: a finished result sits in the rsp register; the next req word is
//   taken while it waits. A second finished result holds the engine, and
//   req.ready low, until rsp drains.
module boundary_tag_heap_allocator #(
	parameter int unsigned ARENA_GRANULES = 4096,
	parameter int unsigned ALIGN_MIN = 16,
	parameter int unsigned ALIGN_MAX = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bth_req_if.sink                    req,
	bth_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [bth_pkg::ADDR_W-1:0] cfg_wdata
);

	// arena base register; low granule bits are ignored
	logic [bth_pkg::ADDR_W-1:0] arena_base_q;
	logic [bth_pkg::ADDR_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_base_q <= '0;
		end else if (cfg_we) begin
			arena_base_q <= cfg_wdata;
		end
	end

	assign base = {arena_base_q[bth_pkg::ADDR_W-1:bth_pkg::GRAN_SHIFT],
		bth_pkg::GRAN_SHIFT'(0)};

	// request side: engine takes a word only while idle
	bth_pkg::cmd_t cmd;
	logic eng_idle, start;
	logic res_valid, res_take;
	bth_pkg::result_t res;

	assign cmd.mode = req.mode;
	assign cmd.request_bytes = req.request_bytes;
	assign cmd.alignment = req.alignment;
	assign cmd.payload_address = req.payload_address;
	assign req.ready = eng_idle;
	assign start = req.valid && eng_idle;

	bth_engine #(
		.ARENA_GRANULES(ARENA_GRANULES),
		.ALIGN_MIN(ALIGN_MIN),
		.ALIGN_MAX(ALIGN_MAX)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .base(base),
		.idle(eng_idle), .res_valid(res_valid), .res_take(res_take), .res(res)
	);

	// result register: decouples the engine from rsp back-pressure
	logic out_vld_q;
	bth_pkg::result_t out_q;

	assign res_take = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = out_q.status;
	assign rsp.granted_address = out_q.granted_address;
	assign rsp.bytes_in_use = out_q.bytes_in_use;
	assign rsp.used_block_count = out_q.used_block_count;
	assign rsp.free_block_count = out_q.free_block_count;

endmodule
